// ----- rtl/tmre_pkg.sv -----
// Shared types, codes and constants of the terminal mouse report encoder.
package tmre_pkg;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int BUTTON_W   = 7;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DIG_W      = 3;
  localparam int CONV_CNT_W = 4;

  // Largest X10 coordinate (one-based) that still fits a report byte
  localparam logic [COORD_W-1:0] X10_COORD_LIMIT = 16'd223;

  // Event kinds
  localparam logic [1:0] FUNC_PRESS   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_MOTION  = 2'd2;

  // Report modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_BUTTONS = 2'd1;
  localparam logic [1:0] MODE_DRAG    = 2'd2;

  // Register indexes
  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_SGR  = 1'b1;

  // Button codes
  localparam logic [BUTTON_W-1:0] BTN_NONE        = 7'd3;
  localparam logic [BUTTON_W-1:0] BTN_WHEEL_FIRST = 7'd64;
  localparam logic [BUTTON_W-1:0] BTN_WHEEL_LAST  = 7'd67;

  // Drop reasons
  localparam logic [2:0] RSN_SENT         = 3'd0;
  localparam logic [2:0] RSN_MODE_OFF     = 3'd1;
  localparam logic [2:0] RSN_OUTSIDE      = 3'd2;
  localparam logic [2:0] RSN_MOTION_1000  = 3'd3;
  localparam logic [2:0] RSN_NOBTN_1002   = 3'd4;
  localparam logic [2:0] RSN_WHEEL_REL    = 3'd5;
  localparam logic [2:0] RSN_X10_RANGE    = 3'd6;

  // Report characters
  localparam logic [7:0] CH_ESC        = 8'h1B;
  localparam logic [7:0] CH_LBRACK     = 8'h5B;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_M_UP       = 8'h4D;
  localparam logic [7:0] CH_M_LOW      = 8'h6D;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] REPORT_OFFSET = 8'd32;
  localparam logic [7:0] MOTION_FLAG   = 8'd32;

  // Report segments walked by the controller
  typedef enum logic [3:0] {
    SEG_ESC     = 4'd0,
    SEG_LBRACK  = 4'd1,
    SEG_LT      = 4'd2,
    SEG_CB      = 4'd3,
    SEG_SEMI1   = 4'd4,
    SEG_COL     = 4'd5,
    SEG_SEMI2   = 4'd6,
    SEG_ROW     = 4'd7,
    SEG_TERM    = 4'd8,
    SEG_X10_M   = 4'd9,
    SEG_X10_CB  = 4'd10,
    SEG_X10_COL = 4'd11,
    SEG_X10_ROW = 4'd12,
    SEG_DROP    = 4'd13
  } seg_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             emit;
    seg_t             seg;
    logic [DIG_W-1:0] dig;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             drop_in;
    logic             sgr;
    logic [DIG_W-1:0] top_cb;
    logic [DIG_W-1:0] top_col;
    logic [DIG_W-1:0] top_row;
  } stat_t;

endpackage

// ----- rtl/tmre_bcd_lane.sv -----
// Shift-and-add-3 binary to decimal converter lane, one bit per cycle while shift is high.
module tmre_bcd_lane
  import tmre_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic               shift,
  input  logic [COORD_W-1:0] bin_in,
  output logic [BCD_W-1:0]   bcd,
  output logic [DIG_W-1:0]   top_dig
);

  logic [COORD_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Load, then shift one binary bit into the digits per cycle while shift is asserted
  always_ff @(posedge clk) begin
    if (load) begin
      bin_r <= bin_in;
      bcd_r <= '0;
    end else if (shift) begin
      bin_r <= {bin_r[COORD_W-2:0], 1'b0};
      bcd_r <= {adj[BCD_W-2:0], bin_r[COORD_W-1]};
    end
  end

  // Index of the leading nonzero digit, zero for the value zero
  always_comb begin
    priority if (bcd_r[19:16] != 4'd0) top_dig = 3'd4;
    else if (bcd_r[15:12] != 4'd0)     top_dig = 3'd3;
    else if (bcd_r[11:8] != 4'd0)      top_dig = 3'd2;
    else if (bcd_r[7:4] != 4'd0)       top_dig = 3'd1;
    else                               top_dig = 3'd0;
  end

  assign bcd = bcd_r;

endmodule

// ----- rtl/tmre_datapath.sv -----
// Datapath: configuration, event filters, button code, decimal lanes and output register.
module tmre_datapath
  import tmre_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [1:0]                cfg_wdata,
  input  logic [1:0]                in_func,
  input  logic [BUTTON_W-1:0]       in_button,
  input  logic [2:0]                in_modifiers,
  input  logic signed [COORD_W-1:0] in_column,
  input  logic signed [COORD_W-1:0] in_grid_row,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  output logic [7:0]                out_byte,
  output logic                      out_last_byte,
  output logic [2:0]                out_drop_reason
);

  logic [1:0]         report_mode_r;
  logic               sgr_enable_r;
  logic [2:0]         reason_r;
  logic [7:0]         cb_r;
  logic [7:0]         term_r;
  logic [COORD_W-1:0] col1_r;
  logic [COORD_W-1:0] row1_r;
  logic [7:0]         byte_r;
  logic               last_r;
  logic [2:0]         rsn_out_r;

  logic [COORD_W-1:0] col1;
  logic [COORD_W-1:0] row1;
  logic               wheel;
  logic [2:0]         reason_in;
  logic [7:0]         cb;
  logic [7:0]         cb_x10;
  logic [BCD_W-1:0]   bcd_cb;
  logic [BCD_W-1:0]   bcd_col;
  logic [BCD_W-1:0]   bcd_row;
  logic [DIG_W-1:0]   top_cb;
  logic [DIG_W-1:0]   top_col;
  logic [DIG_W-1:0]   top_row;
  logic [3:0]         digit;
  logic [7:0]         byte_nxt;
  logic               last_nxt;
  logic [2:0]         rsn_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_mode_r <= MODE_OFF;
      sgr_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE: report_mode_r <= cfg_wdata;
        CFG_IDX_SGR:  sgr_enable_r  <= cfg_wdata[0];
      endcase
    end
  end

  // One-based coordinates and wheel detection
  assign col1  = $unsigned(in_column) + 16'd1;
  assign row1  = $unsigned(in_grid_row) + 16'd1;
  assign wheel = (in_button >= BTN_WHEEL_FIRST) && (in_button <= BTN_WHEEL_LAST);

  // Apply the filters in order
  always_comb begin
    priority if (report_mode_r == MODE_OFF) begin
      reason_in = RSN_MODE_OFF;
    end else if (in_column[COORD_W-1] || in_grid_row[COORD_W-1]) begin
      reason_in = RSN_OUTSIDE;
    end else if (in_func == FUNC_MOTION && report_mode_r == MODE_BUTTONS) begin
      reason_in = RSN_MOTION_1000;
    end else if (in_func == FUNC_MOTION && report_mode_r == MODE_DRAG &&
                 in_button == BTN_NONE) begin
      reason_in = RSN_NOBTN_1002;
    end else if (in_func == FUNC_RELEASE && wheel) begin
      reason_in = RSN_WHEEL_REL;
    end else if (!sgr_enable_r && (col1 > X10_COORD_LIMIT || row1 > X10_COORD_LIMIT)) begin
      reason_in = RSN_X10_RANGE;
    end else begin
      reason_in = RSN_SENT;
    end
  end

  // Build the button code; X10 releases report no button
  assign cb     = ({1'b0, in_button} + ((in_func == FUNC_MOTION) ? MOTION_FLAG : 8'd0)) |
                  {3'b000, in_modifiers, 2'b00};
  assign cb_x10 = (in_func == FUNC_RELEASE) ? {cb[7:3], BTN_NONE[2:0]} : cb;

  // Capture the event
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reason_r <= reason_in;
      cb_r     <= sgr_enable_r ? cb : cb_x10;
      term_r   <= (in_func == FUNC_RELEASE) ? CH_M_LOW : CH_M_UP;
      col1_r   <= col1;
      row1_r   <= row1;
    end
  end

  // Decimal lanes for the three SGR numbers
  tmre_bcd_lane u_lane_cb (
    .clk     (clk),
    .load    (cmd.load),
    .shift   (cmd.shift),
    .bin_in  ({8'd0, cb}),
    .bcd     (bcd_cb),
    .top_dig (top_cb)
  );

  tmre_bcd_lane u_lane_col (
    .clk     (clk),
    .load    (cmd.load),
    .shift   (cmd.shift),
    .bin_in  (col1),
    .bcd     (bcd_col),
    .top_dig (top_col)
  );

  tmre_bcd_lane u_lane_row (
    .clk     (clk),
    .load    (cmd.load),
    .shift   (cmd.shift),
    .bin_in  (row1),
    .bcd     (bcd_row),
    .top_dig (top_row)
  );

  // Pack the status word in field order: drop_in, sgr, top_cb, top_col, top_row
  assign stat = {(reason_in != RSN_SENT), sgr_enable_r, top_cb, top_col, top_row};

  // Pick the current decimal digit
  always_comb begin
    logic [BCD_W-1:0] src;
    unique case (cmd.seg)
      SEG_COL: src = bcd_col;
      SEG_ROW: src = bcd_row;
      default: src = bcd_cb;
    endcase
    unique case (cmd.dig)
      3'd0:    digit = src[3:0];
      3'd1:    digit = src[7:4];
      3'd2:    digit = src[11:8];
      3'd3:    digit = src[15:12];
      3'd4:    digit = src[19:16];
      default: digit = 4'd0;
    endcase
  end

  // Form the next output beat
  always_comb begin
    rsn_nxt  = RSN_SENT;
    last_nxt = 1'b0;
    unique case (cmd.seg)
      SEG_ESC:     byte_nxt = CH_ESC;
      SEG_LBRACK:  byte_nxt = CH_LBRACK;
      SEG_LT:      byte_nxt = CH_LT;
      SEG_CB,
      SEG_COL,
      SEG_ROW:     byte_nxt = CH_ZERO + {4'd0, digit};
      SEG_SEMI1,
      SEG_SEMI2:   byte_nxt = CH_SEMI;
      SEG_TERM: begin
        byte_nxt = term_r;
        last_nxt = 1'b1;
      end
      SEG_X10_M:   byte_nxt = CH_M_UP;
      SEG_X10_CB:  byte_nxt = cb_r + REPORT_OFFSET;
      SEG_X10_COL: byte_nxt = col1_r[7:0] + REPORT_OFFSET;
      SEG_X10_ROW: begin
        byte_nxt = row1_r[7:0] + REPORT_OFFSET;
        last_nxt = 1'b1;
      end
      SEG_DROP: begin
        byte_nxt = 8'd0;
        last_nxt = 1'b1;
        rsn_nxt  = reason_r;
      end
      default:     byte_nxt = 8'd0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_r    <= byte_nxt;
      last_r    <= last_nxt;
      rsn_out_r <= rsn_nxt;
    end
  end

  assign out_byte        = byte_r;
  assign out_last_byte   = last_r;
  assign out_drop_reason = rsn_out_r;

endmodule

// ----- rtl/tmre_ctrl.sv -----
// Controller: accepts an event, runs the decimal conversion and walks the report segments.
module tmre_ctrl
  import tmre_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  seg_t                  seg_r, seg_nxt;
  logic [DIG_W-1:0]      dig_r, dig_nxt;
  logic [CONV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  emit;
  logic                  load;
  logic                  shift;

  assign out_free = !out_valid_r || !out_stall;

  // Sequence the event
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    load      = 1'b0;
    shift     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load    = 1'b1;
          cnt_nxt = '0;
          dig_nxt = '0;
          if (stat.drop_in) begin
            seg_nxt   = SEG_DROP;
            state_nxt = ST_EMIT;
          end else begin
            seg_nxt   = SEG_ESC;
            state_nxt = stat.sgr ? ST_CONV : ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        shift   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          // Advance to the next beat of the report
          unique case (seg_r)
            SEG_ESC:    seg_nxt = SEG_LBRACK;
            SEG_LBRACK: seg_nxt = stat.sgr ? SEG_LT : SEG_X10_M;
            SEG_LT: begin
              seg_nxt = SEG_CB;
              dig_nxt = stat.top_cb;
            end
            SEG_CB: begin
              if (dig_r == '0) seg_nxt = SEG_SEMI1;
              else dig_nxt = dig_r - 1'b1;
            end
            SEG_SEMI1: begin
              seg_nxt = SEG_COL;
              dig_nxt = stat.top_col;
            end
            SEG_COL: begin
              if (dig_r == '0) seg_nxt = SEG_SEMI2;
              else dig_nxt = dig_r - 1'b1;
            end
            SEG_SEMI2: begin
              seg_nxt = SEG_ROW;
              dig_nxt = stat.top_row;
            end
            SEG_ROW: begin
              if (dig_r == '0) seg_nxt = SEG_TERM;
              else dig_nxt = dig_r - 1'b1;
            end
            SEG_X10_M:   seg_nxt = SEG_X10_CB;
            SEG_X10_CB:  seg_nxt = SEG_X10_COL;
            SEG_X10_COL: seg_nxt = SEG_X10_ROW;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the output beat until taken
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seg_r       <= SEG_ESC;
      dig_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      dig_r       <= dig_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pack the command word in field order: load, shift, emit, seg, dig
  assign cmd       = {load, shift, emit, seg_r, dig_r};
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/terminal_mouse_report_encoder_unit.sv -----
// Top level of the terminal mouse report encoder: controller plus datapath.
//
// Each accepted pointer event becomes a run of output beats, one report byte per beat,
// with out_last_byte on the final beat. A dropped event gives a single beat with byte 0
// and its drop reason. An X10 report gives 6 beats, and an SGR report gives 9 to 19
// beats, both at one per cycle while out_stall does not hold the output. An SGR report
// first runs the bit-serial decimal conversion (three lanes, one per number, run in
// parallel) before its first beat. The next event is accepted as soon as the final beat
// sits in the output register. Registers are written through cfg_we, cfg_index
// (0 report_mode, 1 sgr_enable) and cfg_wdata; write them only while the block is idle,
// which the block itself does not enforce.
module terminal_mouse_report_encoder_unit
  import tmre_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [1:0]                cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [BUTTON_W-1:0]       in_button,
  input  logic [2:0]                in_modifiers,
  input  logic signed [COORD_W-1:0] in_column,
  input  logic signed [COORD_W-1:0] in_grid_row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_last_byte,
  output logic [2:0]                out_drop_reason
);

  cmd_t  cmd;
  stat_t stat;

  tmre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmre_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_func),
    .in_button       (in_button),
    .in_modifiers    (in_modifiers),
    .in_column       (in_column),
    .in_grid_row     (in_grid_row),
    .cmd             (cmd),
    .stat            (stat),
    .out_byte        (out_byte),
    .out_last_byte   (out_last_byte),
    .out_drop_reason (out_drop_reason)
  );

endmodule

// ----- rtl/tmre_checker.sv -----
// Port-level checker of the terminal mouse report encoder and its bind.
module tmre_checker
  import tmre_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_we,
  input logic                      cfg_index,
  input logic [1:0]                cfg_wdata,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [1:0]                in_func,
  input logic [BUTTON_W-1:0]       in_button,
  input logic [2:0]                in_modifiers,
  input logic signed [COORD_W-1:0] in_column,
  input logic signed [COORD_W-1:0] in_grid_row,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [7:0]                out_byte,
  input logic                      out_last_byte,
  input logic [2:0]                out_drop_reason
);

  // Block is busy right after taking an event
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous event still in work");

  // No new event while a report is only partly delivered
  a_no_accept_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_byte) |-> in_stall)
    else $error("input ready in the middle of a report");

  // A drop beat is a lone zero byte
  a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drop_reason != RSN_SENT) |-> (out_last_byte && out_byte == 8'd0))
    else $error("drop beat malformed");

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(out_last_byte) && $stable(out_drop_reason)))
    else $error("stalled output beat changed");

endmodule

bind terminal_mouse_report_encoder_unit tmre_checker u_tmre_checker (.*);

// ----- verif/terminal_mouse_report_encoder_unit_tb.sv -----
// Self-checking testbench for the terminal mouse report encoder unit.
`timescale 1ns / 100ps

module terminal_mouse_report_encoder_unit_tb;
  import tmre_pkg::*;

  // Codes the package leaves out
  localparam logic [1:0] MODE_ALL_MOTION = 2'd3;
  localparam logic [1:0] FUNC_OTHER      = 2'd3;

  localparam int RESET_CYCLES   = 10;
  localparam int LONG_HOLD      = 250;
  localparam int IDLE_GUARD     = 8;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEGMENT_EVENTS = 20;

  // One report byte as it leaves the block
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] reason;
  } report_beat_t;

  // Predicts the report of each accepted event and checks the byte stream
  class report_tracker;
    report_beat_t expected_bytes[$];
    logic [1:0]   cur_mode = MODE_OFF;
    logic         cur_sgr  = 1'b0;
    int           events_seen;
    int           drops_seen;
    int           bytes_checked;
    int           mismatches;

    function void apply_reg(logic idx, logic [1:0] val);
      if (idx == CFG_IDX_MODE) cur_mode = val;
      else cur_sgr = val[0];
    endfunction

    function void push_char(logic [7:0] data, logic last);
      report_beat_t b;
      b.data   = data;
      b.last   = last;
      b.reason = RSN_SENT;
      expected_bytes.push_back(b);
    endfunction

    function void push_drop(logic [2:0] reason);
      report_beat_t b;
      b.data   = 8'd0;
      b.last   = 1'b1;
      b.reason = reason;
      expected_bytes.push_back(b);
      drops_seen++;
    endfunction

    // Most significant digit first, no leading zeros
    function void push_decimal(int unsigned v);
      logic [7:0] digs[5];
      int n;
      n = 0;
      do begin
        digs[n] = CH_ZERO + 8'(v % 10);
        v = v / 10;
        n++;
      end while (v != 0);
      for (int i = n - 1; i >= 0; i--) push_char(digs[i], 1'b0);
    endfunction

    function void note_event(logic [1:0] func, logic [BUTTON_W-1:0] button,
                             logic [2:0] mods, logic signed [COORD_W-1:0] col,
                             logic signed [COORD_W-1:0] row);
      logic       wheel;
      logic [7:0] code;
      int         col1;
      int         row1;
      events_seen++;
      wheel = (button >= BTN_WHEEL_FIRST) && (button <= BTN_WHEEL_LAST);
      col1  = int'(col) + 1;
      row1  = int'(row) + 1;
      // Filters in priority order
      if (cur_mode == MODE_OFF) begin
        push_drop(RSN_MODE_OFF);
        return;
      end
      if (col < 0 || row < 0) begin
        push_drop(RSN_OUTSIDE);
        return;
      end
      if (func == FUNC_MOTION) begin
        if (cur_mode == MODE_BUTTONS) begin
          push_drop(RSN_MOTION_1000);
          return;
        end
        if (cur_mode == MODE_DRAG && button == BTN_NONE) begin
          push_drop(RSN_NOBTN_1002);
          return;
        end
      end else if (func == FUNC_RELEASE && wheel) begin
        push_drop(RSN_WHEEL_REL);
        return;
      end
      // Button code: motion flag plus modifier bits
      code = {1'b0, button};
      if (func == FUNC_MOTION) code = code + MOTION_FLAG;
      code = code | {3'b000, mods, 2'b00};
      if (cur_sgr) begin
        push_char(CH_ESC, 1'b0);
        push_char(CH_LBRACK, 1'b0);
        push_char(CH_LT, 1'b0);
        push_decimal(code);
        push_char(CH_SEMI, 1'b0);
        push_decimal(col1);
        push_char(CH_SEMI, 1'b0);
        push_decimal(row1);
        push_char((func == FUNC_RELEASE) ? CH_M_LOW : CH_M_UP, 1'b1);
      end else begin
        // X10 has no release code per button
        if (func == FUNC_RELEASE) code[2:0] = BTN_NONE[2:0];
        if (col1 > int'(X10_COORD_LIMIT) || row1 > int'(X10_COORD_LIMIT)) begin
          push_drop(RSN_X10_RANGE);
          return;
        end
        push_char(CH_ESC, 1'b0);
        push_char(CH_LBRACK, 1'b0);
        push_char(CH_M_UP, 1'b0);
        push_char(REPORT_OFFSET + code, 1'b0);
        push_char(REPORT_OFFSET + 8'(col1), 1'b0);
        push_char(REPORT_OFFSET + 8'(row1), 1'b1);
      end
    endfunction

    function void check_beat(logic [7:0] data, logic last, logic [2:0] reason);
      report_beat_t exp_b;
      if (expected_bytes.size() == 0) begin
        $error("unexpected beat: byte %0h last %0b reason %0d", data, last, reason);
        mismatches++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      bytes_checked++;
      if (data !== exp_b.data) begin
        $error("out_byte mismatch: expected %0h, actual %0h", exp_b.data, data);
        mismatches++;
      end
      if (last !== exp_b.last) begin
        $error("out_last_byte mismatch: expected %0b, actual %0b", exp_b.last, last);
        mismatches++;
      end
      if (reason !== exp_b.reason) begin
        $error("out_drop_reason mismatch: expected %0d, actual %0d", exp_b.reason, reason);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [1:0]                cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_func;
  logic [BUTTON_W-1:0]       in_button;
  logic [2:0]                in_modifiers;
  logic signed [COORD_W-1:0] in_column;
  logic signed [COORD_W-1:0] in_grid_row;
  logic                      out_valid;
  logic                      out_stall;
  logic [7:0]                out_byte;
  logic                      out_last_byte;
  logic [2:0]                out_drop_reason;

  report_tracker tracker = new;
  bit            hold_off_req;
  int            quiet_cycles;
  int            settings_used;

  terminal_mouse_report_encoder_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_button       (in_button),
    .in_modifiers    (in_modifiers),
    .in_column       (in_column),
    .in_grid_row     (in_grid_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_byte   (out_last_byte),
    .out_drop_reason (out_drop_reason)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record accepted events and check returned beats
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.note_event(in_func, in_button, in_modifiers, in_column, in_grid_row);
    if (rst_n && out_valid && !out_stall)
      tracker.check_beat(out_byte, out_last_byte, out_drop_reason);
  end

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Receiver back-pressure: random patterns plus one long hold on request
  initial begin
    int stall_mode;
    int stall_left;
    out_stall = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Present one event and hold it until accepted
  task automatic send_event(input logic [1:0] func, input logic [BUTTON_W-1:0] button,
                            input logic [2:0] mods, input logic signed [COORD_W-1:0] col,
                            input logic signed [COORD_W-1:0] row);
    in_valid     <= 1'b1;
    in_func      <= func;
    in_button    <= button;
    in_modifiers <= mods;
    in_column    <= col;
    in_grid_row  <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every report has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_bytes.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.apply_reg(idx, val);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic sgr);
    settle();
    write_reg(CFG_IDX_MODE, mode);
    write_reg(CFG_IDX_SGR, {1'b0, sgr});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Mostly in-window, some near the X10 limit, some negative or full range
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'($urandom) | 16'h8000;
    if (k <= 2) return 16'($urandom);
    if (k <= 4) return 16'($urandom_range(200, 260));
    if (k == 5) begin
      case ($urandom_range(0, 3))
        0: return 16'sd0;
        1: return 16'sd222;
        2: return 16'sd223;
        default: return 16'sd32767;
      endcase
    end
    if (k <= 8) return 16'($urandom_range(0, 9));
    return 16'($urandom_range(0, 199));
  endfunction

  task automatic random_event();
    logic [1:0]          func;
    logic [BUTTON_W-1:0] button;
    int unsigned         r;
    r = $urandom_range(0, 99);
    if (r < 35) func = FUNC_PRESS;
    else if (r < 65) func = FUNC_RELEASE;
    else if (r < 95) func = FUNC_MOTION;
    else func = FUNC_OTHER;
    r = $urandom_range(0, 9);
    if (r <= 5) button = 7'($urandom_range(0, 3));
    else if (r <= 7) button = 7'($urandom_range(64, 67));
    else button = 7'($urandom_range(0, 127));
    send_event(func, button, 3'($urandom_range(0, 7)), pick_coord(), pick_coord());
  endtask

  // Bursts of events with random gaps
  task automatic random_stream(input int count);
    int burst;
    int gap;
    while (count > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && count > 0) begin
        random_event();
        burst--;
        count--;
      end
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [1:0] seg_mode[6];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = 1'b0;
    cfg_wdata    = 2'd0;
    in_valid     = 1'b0;
    in_func      = FUNC_PRESS;
    in_button    = 7'd0;
    in_modifiers = 3'd0;
    in_column    = 16'sd0;
    in_grid_row  = 16'sd0;
    hold_off_req = 1'b0;
    settings_used = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset mode is off
    send_event(FUNC_PRESS, 7'd0, 3'd0, 16'sd1, 16'sd1);

    // All motion, X10: plain reports, release code, wheel, window and range edges
    set_config(MODE_ALL_MOTION, 1'b0);
    send_event(FUNC_PRESS, 7'd0, 3'd0, 16'sd0, 16'sd0);
    send_event(FUNC_RELEASE, 7'd1, 3'd7, 16'sd5, 16'sd9);
    send_event(FUNC_MOTION, BTN_NONE, 3'd2, 16'sd100, 16'sd50);
    send_event(FUNC_PRESS, BTN_WHEEL_FIRST, 3'd1, 16'sd10, 16'sd10);
    send_event(FUNC_RELEASE, BTN_WHEEL_LAST, 3'd0, 16'sd10, 16'sd10);
    send_event(FUNC_PRESS, 7'd0, 3'd0, -16'sd1, 16'sd0);
    send_event(FUNC_PRESS, 7'd0, 3'd0, 16'sd0, -16'sd32768);
    send_event(FUNC_PRESS, 7'd2, 3'd4, 16'sd222, 16'sd222);
    send_event(FUNC_MOTION, 7'd1, 3'd0, 16'sd223, 16'sd0);
    send_event(FUNC_PRESS, 7'd0, 3'd0, 16'sd0, 16'sd32767);
    send_event(FUNC_OTHER, 7'd127, 3'd7, 16'sd7, 16'sd7);

    // Buttons only, SGR: motion filtered, longest report, lowercase release
    set_config(MODE_BUTTONS, 1'b1);
    send_event(FUNC_MOTION, 7'd0, 3'd0, 16'sd3, 16'sd3);
    send_event(FUNC_PRESS, 7'd127, 3'd7, 16'sd32767, 16'sd32767);
    send_event(FUNC_RELEASE, 7'd0, 3'd0, 16'sd0, 16'sd0);
    send_event(FUNC_PRESS, 7'd0, 3'd0, 16'sd5, -16'sd1);
    send_event(FUNC_RELEASE, 7'd66, 3'd0, 16'sd5, 16'sd5);

    // Drag motion, SGR: buttonless motion filtered, drag with modifiers
    set_config(MODE_DRAG, 1'b1);
    send_event(FUNC_MOTION, BTN_NONE, 3'd0, 16'sd1, 16'sd1);
    send_event(FUNC_MOTION, 7'd0, 3'd5, 16'sd9, 16'sd99);
    send_event(FUNC_MOTION, 7'd127, 3'd0, 16'sd999, 16'sd9999);
    send_event(FUNC_OTHER, BTN_WHEEL_FIRST, 3'd2, 16'sd0, 16'sd0);
    send_event(FUNC_RELEASE, 7'd2, 3'd3, 16'sd40, 16'sd41);

    // Mode off written explicitly
    set_config(MODE_OFF, 1'b1);
    send_event(FUNC_PRESS, 7'd0, 3'd0, 16'sd2, 16'sd2);

    // Long receiver hold while events keep arriving back to back
    set_config(MODE_ALL_MOTION, 1'b1);
    hold_off_req = 1'b1;
    repeat (8) random_event();

    // Random traffic over several register settings
    seg_mode[0] = MODE_ALL_MOTION;
    seg_mode[1] = MODE_DRAG;
    seg_mode[2] = MODE_BUTTONS;
    seg_mode[3] = MODE_ALL_MOTION;
    seg_mode[4] = 2'($urandom_range(0, 3));
    seg_mode[5] = MODE_DRAG;
    for (int s = 0; s < 6; s++) begin
      set_config(seg_mode[s], s[0]);
      random_stream(SEGMENT_EVENTS);
    end

    // Drain, then give stray beats a chance to show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pointer events (%0d dropped) under %0d register settings",
             tracker.events_seen, tracker.drops_seen, settings_used);
    $display("%0d report bytes checked, %0d mismatches",
             tracker.bytes_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
